// ----- rtl/vpid_pkg.sv -----
package vpid_pkg;

   // Operation codes of an input word
   localparam logic OP_RAMP    = 1'b0;
   localparam logic OP_CONTROL = 1'b1;

   // Control register port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_PROP       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_INTEG      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_DERIV      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_STEP       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FF_SPEED_GAIN   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FF_CURRENT_GAIN = 3'd5;

   // Feedforward gains after reset, Q4.16
   localparam logic [19:0] FF_SPEED_GAIN_RESET   = 20'd122675;
   localparam logic [19:0] FF_CURRENT_GAIN_RESET = 20'd100390;

   // Drive limits in counts and in Q.16 counts
   localparam logic signed [14:0] PWM_MAX       = 15'sd16383;
   localparam logic signed [14:0] PWM_MIN       = -15'sd16383;
   localparam logic signed [40:0] DRIVE_LIM     = 41'sd1073676288;
   localparam logic signed [40:0] DRIVE_LIM_NEG = -41'sd1073676288;

   // Accumulator saturation bounds, signed Q24.16
   localparam logic signed [39:0] ACC_MAX = {1'b0, {39{1'b1}}};
   localparam logic signed [39:0] ACC_MIN = {1'b1, {39{1'b0}}};

   typedef struct packed {
      logic               op;
      logic signed [15:0] request_speed;
      logic signed [15:0] speed_estimate;
      logic signed [15:0] current_estimate;
   } item_type;

   typedef struct packed {
      logic [23:0] gain_prop;
      logic [23:0] gain_integ;
      logic [23:0] gain_deriv;
      logic [15:0] ramp_step;
      logic [19:0] ff_speed_gain;
      logic [19:0] ff_current_gain;
      logic [25:0] gain_sum;    // kp + ki + kd
      logic [25:0] gain_last;   // kp + 2*kd
   } cfg_type;

   typedef struct packed {
      logic               op;
      logic signed [43:0] prod_now;
      logic signed [43:0] prod_last;
      logic signed [41:0] prod_prev;
      logic signed [37:0] ff_sum;
      logic signed [15:0] target;
      logic               target_zero;
   } stage_type;

endpackage

// ----- rtl/velocity_pid_feedforward_ramp.sv -----
// A word accepted from the request port passes through the input register,
// the product stage and the result register before its result is valid.
// One word per cycle while the output is not stalled; target and error
// history update in the product stage, the accumulator in the result stage.
// Reset clears all loop state and the pipeline, and loads register defaults.
module velocity_pid_feedforward_ramp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_op,
   input  logic signed [15:0]               req_request_speed,
   input  logic signed [15:0]               req_speed_estimate,
   input  logic signed [15:0]               req_current_estimate,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [14:0]               rsp_pwm_drive,
   output logic                             rsp_drive_clamped,
   output logic signed [15:0]               rsp_target_now,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [vpid_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [vpid_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic in_valid_ff, in_valid_in;
   logic mid_valid_ff, mid_valid_in;
   logic out_valid_ff, out_valid_in;
   vpid_pkg::item_type item_ff;
   vpid_pkg::cfg_type   cfg;
   vpid_pkg::stage_type stage;

   logic adv_out, adv_mid, adv_in;
   logic fire_front, fire_back;

   // Each stage moves when the one after it is empty or moving
   always_comb begin
      adv_out    = !out_valid_ff || !rsp_stall;
      adv_mid    = !mid_valid_ff || adv_out;
      adv_in     = !in_valid_ff || adv_mid;
      fire_front = in_valid_ff && adv_mid;
      fire_back  = mid_valid_ff && adv_out;

      in_valid_in  = adv_in ? req_valid : in_valid_ff;
      mid_valid_in = adv_mid ? in_valid_ff : mid_valid_ff;
      out_valid_in = adv_out ? mid_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the input word
   always_ff @(posedge clock) begin
      if (req_valid && adv_in) begin
         item_ff.op               <= req_op;
         item_ff.request_speed    <= req_request_speed;
         item_ff.speed_estimate   <= req_speed_estimate;
         item_ff.current_estimate <= req_current_estimate;
      end
   end

   assign req_stall = !adv_in;
   assign rsp_valid = out_valid_ff;
   assign csr_ready = 1'b1;

   vpid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   vpid_front u_front (
      .clock (clock),
      .reset (reset),
      .fire  (fire_front),
      .item  (item_ff),
      .cfg   (cfg),
      .stage (stage)
   );

   vpid_back u_back (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire_back),
      .stage         (stage),
      .pwm_drive     (rsp_pwm_drive),
      .drive_clamped (rsp_drive_clamped),
      .target_now    (rsp_target_now)
   );

`ifndef NO_ASSERTIONS
   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> !req_stall)
      else $error("input stalled with an empty result register");

   a_full_pipe_stalls: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && mid_valid_ff && out_valid_ff && rsp_stall) |-> req_stall)
      else $error("input taken while every stage is full and output stalled");

   a_drive_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pwm_drive != 15'sh4000))
      else $error("drive outside the clamp range");

   a_clamp_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_drive_clamped) |->
         (rsp_pwm_drive == vpid_pkg::PWM_MAX || rsp_pwm_drive == vpid_pkg::PWM_MIN))
      else $error("clamp flag set with the drive off its limit");

   a_drained_stays_empty: assert property (@(posedge clock) disable iff (reset)
      (!in_valid_ff && !mid_valid_ff && !req_valid) |=> !mid_valid_ff)
      else $error("product stage filled with no word in flight");
`endif

endmodule

// ----- rtl/vpid_csr.sv -----
module vpid_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [vpid_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [vpid_pkg::CSR_DATA_W-1:0]     csr_data,
   output vpid_pkg::cfg_type                   cfg
);

   vpid_pkg::cfg_type cfg_ff;
   vpid_pkg::cfg_type cfg_in;

   // Decode the write and refresh the combined gains
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            vpid_pkg::CSR_GAIN_PROP:       cfg_in.gain_prop = csr_data;
            vpid_pkg::CSR_GAIN_INTEG:      cfg_in.gain_integ = csr_data;
            vpid_pkg::CSR_GAIN_DERIV:      cfg_in.gain_deriv = csr_data;
            vpid_pkg::CSR_RAMP_STEP:       cfg_in.ramp_step = csr_data[15:0];
            vpid_pkg::CSR_FF_SPEED_GAIN:   cfg_in.ff_speed_gain = csr_data[19:0];
            vpid_pkg::CSR_FF_CURRENT_GAIN: cfg_in.ff_current_gain = csr_data[19:0];
            default: ;
         endcase
      end
      cfg_in.gain_sum  = 26'(cfg_in.gain_prop) + 26'(cfg_in.gain_integ)
                       + 26'(cfg_in.gain_deriv);
      cfg_in.gain_last = 26'(cfg_in.gain_prop) + {1'b0, cfg_in.gain_deriv, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_prop       <= '0;
         cfg_ff.gain_integ      <= '0;
         cfg_ff.gain_deriv      <= '0;
         cfg_ff.ramp_step       <= '0;
         cfg_ff.ff_speed_gain   <= vpid_pkg::FF_SPEED_GAIN_RESET;
         cfg_ff.ff_current_gain <= vpid_pkg::FF_CURRENT_GAIN_RESET;
         cfg_ff.gain_sum        <= '0;
         cfg_ff.gain_last       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/vpid_front.sv -----
module vpid_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  vpid_pkg::item_type  item,
   input  vpid_pkg::cfg_type   cfg,
   output vpid_pkg::stage_type stage
);

   logic signed [15:0] target_ff, target_in;
   logic signed [16:0] err_last_ff, err_last_in;
   logic signed [16:0] err_prev_ff, err_prev_in;
   vpid_pkg::stage_type stage_ff, stage_in;

   logic signed [17:0] ramp_up, ramp_dn, ramp_raw;
   logic signed [15:0] ramp_sat;
   logic signed [16:0] error_now;
   logic signed [36:0] ff_speed, ff_current;

   // Step the target toward the request and saturate
   always_comb begin
      ramp_up = 18'(target_ff) + $signed({2'b00, cfg.ramp_step});
      ramp_dn = 18'(target_ff) - $signed({2'b00, cfg.ramp_step});
      if (item.request_speed > target_ff) begin
         ramp_raw = ramp_up;
      end else if (item.request_speed < target_ff) begin
         ramp_raw = ramp_dn;
      end else begin
         ramp_raw = 18'(target_ff);
      end
      if (ramp_raw > 18'sd32767) begin
         ramp_sat = 16'sh7FFF;
      end else if (ramp_raw < -18'sd32768) begin
         ramp_sat = 16'sh8000;
      end else begin
         ramp_sat = $signed(ramp_raw[15:0]);
      end
   end

   // Error, the gain products of the incremental update and the feedforward
   always_comb begin
      error_now  = 17'(target_ff) - 17'(item.speed_estimate);
      ff_speed   = $signed({1'b0, cfg.ff_speed_gain}) * target_ff;
      ff_current = $signed({1'b0, cfg.ff_current_gain}) * item.current_estimate;

      stage_in.op          = item.op;
      stage_in.prod_now    = $signed({1'b0, cfg.gain_sum}) * error_now;
      stage_in.prod_last   = $signed({1'b0, cfg.gain_last}) * err_last_ff;
      stage_in.prod_prev   = $signed({1'b0, cfg.gain_deriv}) * err_prev_ff;
      stage_in.ff_sum      = 38'(ff_speed) + 38'(ff_current);
      stage_in.target      = (item.op == vpid_pkg::OP_RAMP) ? ramp_sat : target_ff;
      stage_in.target_zero = (target_ff == 16'sd0);
   end

   // Advance target and error history as a word passes
   always_comb begin
      target_in   = target_ff;
      err_last_in = err_last_ff;
      err_prev_in = err_prev_ff;
      if (fire) begin
         if (item.op == vpid_pkg::OP_RAMP) begin
            target_in = ramp_sat;
         end else begin
            err_prev_in = err_last_ff;
            err_last_in = error_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= '0;
         err_last_ff <= '0;
         err_prev_ff <= '0;
      end else begin
         target_ff   <= target_in;
         err_last_ff <= err_last_in;
         err_prev_ff <= err_prev_in;
      end
   end

   // Hold the stage word until the next one passes
   always_ff @(posedge clock) begin
      if (fire) begin
         stage_ff <= stage_in;
      end
   end

   assign stage = stage_ff;

endmodule

// ----- rtl/vpid_back.sv -----
module vpid_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  vpid_pkg::stage_type stage,
   output logic signed [14:0]  pwm_drive,
   output logic                drive_clamped,
   output logic signed [15:0]  target_now
);

   logic signed [39:0] acc_ff, acc_in;
   logic signed [14:0] drive_ff, drive_in;
   logic               clamp_ff, clamp_in;
   logic signed [14:0] pwm_ff, pwm_in;
   logic               clamped_ff, clamped_in;
   logic signed [15:0] target_ff;

   logic signed [45:0] inc;
   logic signed [37:0] inc_q16;
   logic signed [40:0] acc_wide;
   logic signed [39:0] acc_sat;
   logic signed [40:0] drive_sum;
   logic signed [14:0] drive_new;
   logic               clamp_new;

   // Sum the increment, accumulate with saturation, add feedforward, clamp
   always_comb begin
      inc      = 46'(stage.prod_now) - 46'(stage.prod_last) + 46'(stage.prod_prev);
      inc_q16  = $signed(inc[45:8]);
      acc_wide = 41'(acc_ff) + 41'(inc_q16);
      if (acc_wide[40] != acc_wide[39]) begin
         acc_sat = acc_wide[40] ? vpid_pkg::ACC_MIN : vpid_pkg::ACC_MAX;
      end else begin
         acc_sat = $signed(acc_wide[39:0]);
      end
      drive_sum = 41'(acc_sat) + 41'(stage.ff_sum);
      if (drive_sum > vpid_pkg::DRIVE_LIM) begin
         drive_new = vpid_pkg::PWM_MAX;
         clamp_new = 1'b1;
      end else if (drive_sum < vpid_pkg::DRIVE_LIM_NEG) begin
         drive_new = vpid_pkg::PWM_MIN;
         clamp_new = 1'b1;
      end else begin
         drive_new = $signed(drive_sum[30:16]);
         clamp_new = 1'b0;
      end
   end

   // Update control state on a control word; a zero target drops the sum
   always_comb begin
      acc_in   = acc_ff;
      drive_in = drive_ff;
      clamp_in = clamp_ff;
      if (fire && stage.op == vpid_pkg::OP_CONTROL) begin
         acc_in   = stage.target_zero ? 40'sd0 : acc_sat;
         drive_in = drive_new;
         clamp_in = clamp_new;
      end
   end

   // Result word: fresh drive on control, held drive on ramp
   always_comb begin
      pwm_in     = (stage.op == vpid_pkg::OP_CONTROL) ? drive_new : drive_ff;
      clamped_in = (stage.op == vpid_pkg::OP_CONTROL) ? clamp_new : clamp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         drive_ff <= '0;
         clamp_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         drive_ff <= drive_in;
         clamp_ff <= clamp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         pwm_ff     <= pwm_in;
         clamped_ff <= clamped_in;
         target_ff  <= stage.target;
      end
   end

   assign pwm_drive     = pwm_ff;
   assign drive_clamped = clamped_ff;
   assign target_now    = target_ff;

endmodule
